/* rtl/dntl_pkg.sv */
// Shared types and constants for the day/night threshold learner.
// No dependencies; imported by the top-level unit of the block.
`default_nettype none
package dntl_pkg;

  localparam int unsigned BINS  = 256;
  localparam int unsigned BIN_W = 8;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned PCT_W = 15;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

  // Input transaction: pixel or compute request
  typedef struct packed {
    logic             kind;
    logic [7:0]       pixel;
    logic             is_day;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic             ok;
    logic [7:0]       intensity_threshold;
    logic [PCT_W-1:0] percent_threshold;
    logic             overflow;
  } out_t;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

endpackage
`default_nettype wire

/* rtl/dntl_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module dntl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

/* rtl/day_night_threshold_learner_unit.sv */
// Top level of the day/night threshold learner: histograms, walk, divider.
// Depends on dntl_pkg and dntl_ram.
//
//   channel   dir  handshake              payload
//   in        in   in_valid_i/in_stall_o  in_data_i  (dntl_pkg::in_t)
//   out       out  out_valid_o/out_stall_i out_data_o (dntl_pkg::out_t)
//
// Pixel transaction: histogram RAM read in the accept cycle, then write-back.
// Compute transaction: accept cycle, then states CRD, CACC, CMUL and CCMP per
// bin over BINS bins, DEN and DIV for the percent division, and DONE to issue;
// an empty class goes from accept to DONE. A stalled result holds DONE.
// After reset a clearing pass writes zero to every bin of both RAMs.
// One transaction in flight; input stalls while busy. A waiting result sits in
// the output register, and pixels are taken meanwhile.
`default_nettype none
module day_night_threshold_learner_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire dntl_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output dntl_pkg::out_t      out_data_o
);
  import dntl_pkg::*;

  localparam int unsigned NUM_W = 2*CNT_W + 1 + 14;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_PWR  = 4'd2;
  localparam logic [3:0] ST_CRD  = 4'd3;
  localparam logic [3:0] ST_CACC = 4'd4;
  localparam logic [3:0] ST_CMUL = 4'd5;
  localparam logic [3:0] ST_CCMP = 4'd6;
  localparam logic [3:0] ST_DEN  = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [BIN_W-1:0]   idx_q, idx_d;
  logic [BIN_W-1:0]   pix_q, pix_d;
  logic               day_q, day_d;
  logic [CNT_W-1:0]   day_total_q, day_total_d;
  logic [CNT_W-1:0]   night_total_q, night_total_d;
  logic               sat_q, sat_d;
  logic [CNT_W-1:0]   sd_q, sd_d, sn_q, sn_d;
  logic [2*CNT_W-1:0] l_q, l_d, r_q, r_d;
  logic [2*CNT_W-1:0] best_l_q, best_l_d, best_r_q, best_r_d;
  logic [BIN_W-1:0]   pos_q, pos_d;
  logic [NUM_W-1:0]   num_q, num_d, dsh_q, dsh_d;
  logic [3:0]         bit_q, bit_d;
  logic [PCT_W-1:0]   pct_q, pct_d;
  logic               ok_q, ok_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  // Histogram RAM port signals
  logic [BIN_W-1:0]   ram_addr;
  logic               day_we, night_we;
  logic [CNT_W-1:0]   day_wdata, night_wdata, day_rdata, night_rdata;

  logic [CNT_W:0]     sd_sum, sn_sum;
  logic [2*CNT_W:0]   lhs, rhs, s_sum;
  logic [CNT_W-1:0]   cnt_old;
  logic               slot_free;

  dntl_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_day_ram (
    .clk_i   (clk_i),
    .we_i    (day_we),
    .addr_i  (ram_addr),
    .wdata_i (day_wdata),
    .rdata_o (day_rdata)
  );

  dntl_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_night_ram (
    .clk_i   (clk_i),
    .we_i    (night_we),
    .addr_i  (ram_addr),
    .wdata_i (night_wdata),
    .rdata_o (night_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Walk arithmetic: clamped suffix sums and the cross-multiplied compare
  assign sd_sum  = {1'b0, sd_q} + {1'b0, day_rdata};
  assign sn_sum  = {1'b0, sn_q} + {1'b0, night_rdata};
  assign lhs     = {1'b0, l_q} + {1'b0, best_r_q};
  assign rhs     = {1'b0, best_l_q} + {1'b0, r_q};
  assign s_sum   = {1'b0, best_l_q} + {1'b0, best_r_q};
  assign cnt_old = day_q ? day_rdata : night_rdata;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    pix_d         = pix_q;
    day_d         = day_q;
    day_total_d   = day_total_q;
    night_total_d = night_total_q;
    sat_d         = sat_q;
    sd_d          = sd_q;
    sn_d          = sn_q;
    l_d           = l_q;
    r_d           = r_q;
    best_l_d      = best_l_q;
    best_r_d      = best_r_q;
    pos_d         = pos_q;
    num_d         = num_q;
    dsh_d         = dsh_q;
    bit_d         = bit_q;
    pct_d         = pct_q;
    ok_d          = ok_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    ram_addr      = idx_q;
    day_we        = 1'b0;
    night_we      = 1'b0;
    day_wdata     = '0;
    night_wdata   = '0;

    case (state_q)
      // Zero both histograms after reset
      ST_CLR: begin
        day_we   = 1'b1;
        night_we = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (idx_q == BIN_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_addr = in_data_i.pixel;
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_PIXEL) begin
            pix_d   = in_data_i.pixel;
            day_d   = in_data_i.is_day;
            state_d = ST_PWR;
          end else if (day_total_q == '0 || night_total_q == '0) begin
            ok_d    = 1'b0;
            pos_d   = '0;
            pct_d   = '0;
            state_d = ST_DONE;
          end else begin
            ok_d    = 1'b1;
            sd_d    = '0;
            sn_d    = '0;
            idx_d   = BIN_LAST;
            state_d = ST_CRD;
          end
        end
      end
      // Saturating write-back of the bin and its class total
      ST_PWR: begin
        ram_addr = pix_q;
        if (day_q) begin
          day_we    = 1'b1;
          day_wdata = (cnt_old == CNT_MAX) ? CNT_MAX : cnt_old + 1'b1;
          day_total_d = (day_total_q == CNT_MAX) ? CNT_MAX : day_total_q + 1'b1;
          if (cnt_old == CNT_MAX || day_total_q == CNT_MAX) sat_d = 1'b1;
        end else begin
          night_we    = 1'b1;
          night_wdata = (cnt_old == CNT_MAX) ? CNT_MAX : cnt_old + 1'b1;
          night_total_d = (night_total_q == CNT_MAX) ? CNT_MAX
                                                     : night_total_q + 1'b1;
          if (cnt_old == CNT_MAX || night_total_q == CNT_MAX) sat_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_CRD: begin
        state_d = ST_CACC;
      end
      ST_CACC: begin
        sd_d = (sd_sum > {1'b0, day_total_q}) ? day_total_q : sd_sum[CNT_W-1:0];
        sn_d = (sn_sum > {1'b0, night_total_q}) ? night_total_q
                                                : sn_sum[CNT_W-1:0];
        state_d = ST_CMUL;
      end
      ST_CMUL: begin
        l_d     = sd_q * night_total_q;
        r_d     = sn_q * day_total_q;
        state_d = ST_CCMP;
      end
      // Keep the lowest bin among equal maxima
      ST_CCMP: begin
        if (idx_q == BIN_LAST || lhs >= rhs) begin
          best_l_d = l_q;
          best_r_d = r_q;
          pos_d    = idx_q;
        end
        if (idx_q == '0) begin
          state_d = ST_DEN;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = ST_CRD;
        end
      end
      // num = 12800*s, divisor D*N aligned to the top quotient bit
      ST_DEN: begin
        num_d   = (NUM_W'(s_sum) << 13) + (NUM_W'(s_sum) << 12) + (NUM_W'(s_sum) << 9);
        dsh_d   = NUM_W'(day_total_q * night_total_q) << 14;
        bit_d   = 4'd14;
        pct_d   = '0;
        state_d = ST_DIV;
      end
      // Restoring division, one quotient bit per cycle
      ST_DIV: begin
        if (num_q >= dsh_q) begin
          num_d = num_q - dsh_q;
          pct_d = {pct_q[PCT_W-2:0], 1'b1};
        end else begin
          pct_d = {pct_q[PCT_W-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d                 = 1'b1;
          out_d.ok                    = ok_q;
          out_d.intensity_threshold   = pos_q;
          out_d.percent_threshold     = pct_q;
          out_d.overflow              = sat_q;
          state_d                     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      idx_q         <= '0;
      day_total_q   <= '0;
      night_total_q <= '0;
      sat_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      sd_q          <= '0;
      sn_q          <= '0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      day_total_q   <= day_total_d;
      night_total_q <= night_total_d;
      sat_q         <= sat_d;
      out_valid_q   <= out_valid_d;
      sd_q          <= sd_d;
      sn_q          <= sn_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    day_q    <= day_d;
    l_q      <= l_d;
    r_q      <= r_d;
    best_l_q <= best_l_d;
    best_r_q <= best_r_d;
    pos_q    <= pos_d;
    num_q    <= num_d;
    dsh_q    <= dsh_d;
    bit_q    <= bit_d;
    pct_q    <= pct_d;
    ok_q     <= ok_d;
    out_q    <= out_d;
  end

  // Suffix sums never exceed their class totals
  a_sd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sd_q <= day_total_q) && (sn_q <= night_total_q))
    else $error("suffix sum above class total");

  // An empty-class result carries zero thresholds
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |->
      (out_data_o.intensity_threshold == '0) && (out_data_o.percent_threshold == '0))
    else $error("empty-class result not zeroed");

  // Percent stays within 100 percent in 1/256 units
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.percent_threshold <= PCT_W'(25600))
    else $error("percent out of range");

  // The histograms are only written during clearing or pixel write-back
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (day_we || night_we) |-> (state_q == ST_CLR || state_q == ST_PWR))
    else $error("histogram written outside write states");

endmodule
`default_nettype wire
